// ----- sv/tabms_pkg.sv -----
// Shared types and constants for the two-arm bandit mode selector.
// Holds the word structs, the controller states and the command/status bundles.
// No dependencies.
`default_nettype none

package tabms_pkg;

  // field widths
  localparam int unsigned TICK_W  = 64;
  localparam int unsigned CONF_W  = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned TALLY_W = 32;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // conflict scaling: conflicts * 10000 fits in CONF_W + MUL_W bits
  localparam int unsigned MUL_W     = 14;
  localparam int unsigned MUL10K    = 10000;
  localparam int unsigned NUM_INT_W = CONF_W + MUL_W;

  // score averaging and repeat decay
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned COEF_KEEP   = 55706;
  localparam int unsigned COEF_NEW    = 9830;
  localparam int unsigned COEF_SHIFT  = 16;
  localparam int unsigned DECAY_W     = 16;
  localparam int unsigned DECAY_ONE   = 32768;
  localparam int unsigned DECAY_STEP  = 31130;
  localparam int unsigned DECAY_SHIFT = 15;
  localparam int unsigned DPROD_W     = 31;

  // shared multiply-accumulate unit
  localparam int unsigned TERM_W = 68;
  localparam int unsigned OPH_W  = 34;
  localparam int unsigned OP_W   = OPH_W + 1;
  localparam int unsigned PROD_W = OP_W + COEF_W + 1;
  localparam int unsigned ACC_W  = 88;

  // last sequencer count of each multiply pass
  localparam int unsigned MAC_LAST = 4;
  localparam int unsigned DEC_LAST = 2;

  localparam logic [CFG_W-1:0] MODES_RESET = CFG_W'(2);

  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic [CONF_W-1:0] conflict_count;
    logic [MODE_W-1:0] ran_mode;
  } in_word_t;

  typedef struct packed {
    logic               chosen_mode;
    logic [TICK_W-1:0]  reward_value;
    logic [TALLY_W-1:0] chosen_total;
  } out_word_t;

  typedef enum logic [2:0] {
    MAC_SCORE_LO,
    MAC_SCORE_HI,
    MAC_TERM_LO,
    MAC_TERM_HI,
    MAC_DEC_LO,
    MAC_DEC_HI
  } mac_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_REWARD,
    ST_TERM,
    ST_MAC,
    ST_SCORE,
    ST_DECAY,
    ST_PICK
  } ctrl_state_e;

  typedef struct packed {
    logic    capture;
    logic    div_load;
    logic    div_step;
    logic    reward_ld;
    logic    term_ld;
    logic    acc_clr;
    logic    mul_en;
    mac_op_e mac_op;
    logic    acc_add;
    logic    score_wr;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/tabms_dp.sv -----
// Datapath of the bandit mode selector: divider, shared multiply-accumulate,
// per-mode state and the output register. Depends on tabms_pkg.
`default_nettype none

module tabms_dp #(
  parameter int unsigned FRAC_BITS = tabms_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tabms_pkg::in_word_t            in_data_i,
  input  logic                           cfg_we_i,
  input  logic [tabms_pkg::CFG_W-1:0]    cfg_data_i,
  input  tabms_pkg::dp_cmd_t             cmd_i,
  output tabms_pkg::dp_stat_t            stat_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output tabms_pkg::out_word_t           out_data_o
);
  import tabms_pkg::*;

  localparam int unsigned NUM_W = NUM_INT_W + FRAC_BITS;
  localparam int unsigned QX_W  = (NUM_W > TICK_W) ? NUM_W : TICK_W + 1;

  function automatic logic [TICK_W-1:0] sat64(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-TICK_W:0] top;
    top = v[ACC_W-1:TICK_W-1];
    if ((&top) || !(|top)) begin
      sat64 = v[TICK_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat64 = {1'b1, {(TICK_W-1){1'b0}}};
    end else begin
      sat64 = {1'b0, {(TICK_W-1){1'b1}}};
    end
  endfunction

  // architectural state
  logic [CFG_W-1:0]         modes_q;
  logic [TICK_W-1:0]        prev_ticks_q;
  logic [TICK_W-1:0]        prev_reward_q [2];
  logic signed [TICK_W-1:0] score_q [2];
  logic [DECAY_W-1:0]       decay_q;
  logic [TALLY_W-1:0]       tally_q [2];
  logic                     out_valid_q;
  out_word_t                out_q;

  // work registers
  logic [TICK_W-1:0]        tick_q;
  logic [CONF_W-1:0]        conf_q;
  logic                     mode_q;
  logic [TICK_W:0]          d_q;
  logic [NUM_W-1:0]         dvd_q;
  logic [TICK_W:0]          rem_q;
  logic [NUM_W-1:0]         quo_q;
  logic [TICK_W-1:0]        reward_q;
  logic [TERM_W-1:0]        term_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_hi_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [TICK_W-1:0]        elapsed;
  logic [NUM_INT_W-1:0]     num;
  logic [TICK_W+1:0]        r2;
  logic [TICK_W+1:0]        r2_sub;
  logic                     ge;
  logic [QX_W-1:0]          quo_x;
  logic [TERM_W-1:0]        r3;
  logic [TERM_W-1:0]        p3;
  logic signed [TICK_W-1:0] score_sel;
  logic [TERM_W-1:0]        op_full;
  logic                     op_hi;
  logic [OP_W-1:0]          op_x;
  logic [COEF_W-1:0]        coef;
  logic signed [PROD_W-1:0] prod_d;
  logic [ACC_W-1:0]         prod_ext;
  logic signed [TICK_W-1:0] sel_val;
  logic signed [TICK_W-1:0] val0;
  logic signed [TICK_W-1:0] val1;
  logic                     best;
  logic [TALLY_W-1:0]       tally_inc;
  logic [DPROD_W-1:0]       decay_prod;
  logic [DECAY_W-1:0]       decay_d;

  // elapsed ticks and scaled conflicts
  assign elapsed = (tick_q >= prev_ticks_q) ? tick_q - prev_ticks_q : tick_q;
  assign num     = NUM_INT_W'(conf_q) * NUM_INT_W'(MUL10K);

  // one restoring step per cycle
  assign r2     = {rem_q, dvd_q[NUM_W-1]};
  assign ge     = (r2 >= {1'b0, d_q});
  assign r2_sub = r2 - {1'b0, d_q};
  assign quo_x  = QX_W'(quo_q);

  assign r3 = TERM_W'(reward_q);
  assign p3 = TERM_W'(prev_reward_q[mode_q]);

  // multiply operand: a 34-bit half of a 68-bit signed word
  assign score_sel = score_q[mode_q];

  always_comb begin
    op_hi = (cmd_i.mac_op inside {MAC_SCORE_HI, MAC_TERM_HI, MAC_DEC_HI});
    if (cmd_i.mac_op inside {MAC_TERM_LO, MAC_TERM_HI}) begin
      op_full = term_q;
    end else begin
      op_full = {{(TERM_W-TICK_W){score_sel[TICK_W-1]}}, score_sel};
    end
    if (op_hi) begin
      op_x = {op_full[TERM_W-1], op_full[TERM_W-1:OPH_W]};
    end else begin
      op_x = {1'b0, op_full[OPH_W-1:0]};
    end
    case (cmd_i.mac_op)
      MAC_SCORE_LO, MAC_SCORE_HI: coef = COEF_W'(COEF_KEEP);
      MAC_TERM_LO, MAC_TERM_HI:   coef = COEF_W'(COEF_NEW);
      default:                    coef = decay_q;
    endcase
  end

  assign prod_d   = $signed(op_x) * $signed({1'b0, coef});
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // selection: active mode seen through the repeat decay
  assign sel_val = sat64(acc_q >>> DECAY_SHIFT);
  assign val0    = mode_q ? score_q[0] : sel_val;
  assign val1    = mode_q ? sel_val : score_q[1];

  always_comb begin
    case (modes_q)
      CFG_W'(0): best = mode_q;
      CFG_W'(1): best = 1'b0;
      default:   best = (val1 > val0);
    endcase
  end

  assign tally_inc  = tally_q[best] + TALLY_W'(1);
  assign decay_prod = DPROD_W'(decay_q) * DPROD_W'(DECAY_STEP);
  assign decay_d    = (best == mode_q) ? decay_prod[DPROD_W-1:DECAY_SHIFT]
                                       : DECAY_W'(DECAY_ONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q          <= MODES_RESET;
      prev_ticks_q     <= '0;
      prev_reward_q[0] <= '0;
      prev_reward_q[1] <= '0;
      score_q[0]       <= '0;
      score_q[1]       <= '0;
      decay_q          <= DECAY_W'(DECAY_ONE);
      tally_q[0]       <= '0;
      tally_q[1]       <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        modes_q <= cfg_data_i;
      end
      if (cmd_i.div_load) begin
        prev_ticks_q <= tick_q;
      end
      if (cmd_i.score_wr) begin
        score_q[mode_q]       <= sat64(acc_q >>> COEF_SHIFT);
        prev_reward_q[mode_q] <= reward_q;
      end
      if (cmd_i.out_load) begin
        tally_q[best] <= tally_inc;
        decay_q       <= decay_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tick_q <= in_data_i.tick_count;
      conf_q <= in_data_i.conflict_count;
      mode_q <= (in_data_i.ran_mode == MODE_W'(1));
    end
    if (cmd_i.div_load) begin
      d_q   <= {1'b0, elapsed} + (TICK_W+1)'(1);
      dvd_q <= {num, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? r2_sub[TICK_W:0] : r2[TICK_W:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
      dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
    end
    if (cmd_i.reward_ld) begin
      reward_q <= (|quo_x[QX_W-1:TICK_W]) ? '1 : quo_x[TICK_W-1:0];
    end
    if (cmd_i.term_ld) begin
      term_q <= r3 + (r3 << 1) - (p3 << 1);
    end
    if (cmd_i.mul_en) begin
      prod_q    <= prod_d;
      prod_hi_q <= op_hi;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + $signed(prod_hi_q ? (prod_ext << OPH_W) : prod_ext);
    end
    if (cmd_i.out_load) begin
      out_q.chosen_mode  <= best;
      out_q.reward_value <= reward_q;
      out_q.chosen_total <= tally_inc;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

`ifndef SYNTH
  a_decay_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decay_q <= DECAY_W'(DECAY_ONE))
    else $error("repeat decay above one");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("output load did not raise valid");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_load |=> (d_q != '0))
    else $error("divisor loaded as zero");
`endif

endmodule

`default_nettype wire

// ----- sv/tabms_ctrl.sv -----
// Sequencer of the bandit mode selector: steps the datapath through division,
// score update, decay scaling and selection. Depends on tabms_pkg.
`default_nettype none

module tabms_ctrl #(
  parameter int unsigned FRAC_BITS = tabms_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tabms_pkg::dp_stat_t stat_i,
  output tabms_pkg::dp_cmd_t  cmd_o
);
  import tabms_pkg::*;

  localparam int unsigned NUM_W = NUM_INT_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] DIV_END = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] MAC_END = CNT_W'(MAC_LAST);
  localparam logic [CNT_W-1:0] DEC_END = CNT_W'(DEC_LAST);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == DIV_END) begin
          state_d = ST_REWARD;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_REWARD: state_d = ST_TERM;
      ST_TERM:   state_d = ST_MAC;
      ST_MAC: begin
        if (cnt_q == MAC_END) begin
          state_d = ST_SCORE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SCORE: state_d = ST_DECAY;
      ST_DECAY: begin
        if (cnt_q == DEC_END) begin
          state_d = ST_PICK;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_PICK: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.mac_op = MAC_SCORE_LO;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_PREP:   cmd_o.div_load  = 1'b1;
      ST_DIV:    cmd_o.div_step  = 1'b1;
      ST_REWARD: cmd_o.reward_ld = 1'b1;
      ST_TERM: begin
        cmd_o.term_ld = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_MAC: begin
        cmd_o.mul_en  = (cnt_q != MAC_END);
        cmd_o.acc_add = (cnt_q != '0);
        case (cnt_q)
          CNT_W'(0): cmd_o.mac_op = MAC_SCORE_LO;
          CNT_W'(1): cmd_o.mac_op = MAC_SCORE_HI;
          CNT_W'(2): cmd_o.mac_op = MAC_TERM_LO;
          default:   cmd_o.mac_op = MAC_TERM_HI;
        endcase
      end
      ST_SCORE: begin
        cmd_o.score_wr = 1'b1;
        cmd_o.acc_clr  = 1'b1;
      end
      ST_DECAY: begin
        cmd_o.mul_en  = (cnt_q != DEC_END);
        cmd_o.acc_add = (cnt_q != '0);
        cmd_o.mac_op  = (cnt_q == '0) ? MAC_DEC_LO : MAC_DEC_HI;
      end
      ST_PICK: cmd_o.out_load = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

`ifndef SYNTH
  a_div_runs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q != DIV_END) |=> (state_q == ST_DIV))
    else $error("divider left early");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("output overwritten while occupied");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_PREP && !in_ready_o))
    else $error("accepted word did not start work");
`endif

endmodule

`default_nettype wire

// ----- sv/two_arm_bandit_mode_selector.sv -----
// Two-arm bandit mode selector, top level; uses tabms_pkg, tabms_ctrl, tabms_dp.
// The controller takes one word at a time: the next input word is accepted only after
// the result of the last is loaded into the output register. The divider is a
// bit-serial restoring divider (one quotient bit a cycle).
// Reset clears scores, rewards, tallies and tick history, sets decay to one and
// modes_in_use to two; no clearing pass, ready as soon as reset is released.
`default_nettype none

module two_arm_bandit_mode_selector #(
  parameter int unsigned FRAC_BITS = tabms_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tabms_pkg::in_word_t         in_data_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tabms_pkg::out_word_t        out_data_o,
  // modes_in_use register
  input  logic                        cfg_we_i,
  input  logic [tabms_pkg::CFG_W-1:0] cfg_data_i
);
  import tabms_pkg::*;

  // The controller walks one word at a time through:
  //   capture -> load divider (elapsed ticks, conflicts * 10000)
  //   -> NUM_INT_W + FRAC_BITS restoring steps -> saturate reward
  //   -> trend term -> score average on the shared 35x17 multiplier (4 passes)
  //   -> write score -> decay scaling of the active mode (2 passes)
  //   -> pick and load the output register.
  // The output register frees the input side: a new word is taken while the
  // previous result still waits; the pick step holds only if that register
  // is still occupied when the next result is ready.

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tabms_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tabms_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for two_arm_bandit_mode_selector: a directed table, then random
// phases under each modes_in_use setting, checked word by word against a local predictor.
// Depends on tabms_pkg (word structs, widths) and the selector RTL.

module testbench;
  import tabms_pkg::*;

  localparam int unsigned FRAC             = FRAC_BITS_DEF;
  localparam int unsigned OPENING_ROWS     = 16;
  localparam int unsigned RANDOM_PER_PHASE = 130;
  localparam int unsigned PHASES           = 5;
  localparam int unsigned DRAIN_CYCLES     = 100;

  // score averaging and repeat decay, Q16 and Q1.15
  localparam logic signed [127:0] KEEP_Q16   = 128'sd55706;
  localparam logic signed [127:0] FRESH_Q16  = 128'sd9830;
  localparam logic [15:0]         DECAY_UNIT = 16'd32768;
  localparam logic [31:0]         DECAY_MULT = 32'd31130;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } probe_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_word_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  // predictor copy of the selector state
  logic [CFG_W-1:0]     modes_sel;
  logic [63:0]          tick_hist;
  logic [63:0]          arm_reward [2];
  logic signed [63:0]   arm_score [2];
  logic [15:0]          decay_now;
  logic [31:0]          pick_tally [2];

  out_word_t            awaited_picks [$];
  int unsigned          mismatch_count = 0;
  logic                 steady = 1'b0;     // no idling on either side while set
  logic                 last_choice = 1'b0;
  logic [63:0]          tick_now;
  probe_row_t           opening_rows [OPENING_ROWS];

  always #5 clk_i = ~clk_i;

  two_arm_bandit_mode_selector #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clamp a wide signed value into the signed 64-bit range.
  function automatic logic signed [63:0] clip_s64(input logic signed [127:0] v);
    if (v[127:63] == '0 || v[127:63] == '1) begin
      return v[63:0];
    end
    return v[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
  endfunction

  // Advance the predicted state by one input word and return the expected result word.
  task automatic pick_next_mode(input in_word_t w, output out_word_t pick);
    logic [63:0]         elapsed;
    logic [64:0]         span;
    logic [127:0]        scaled;
    logic [127:0]        quot;
    logic [63:0]         reward;
    logic signed [127:0] blend;
    logic signed [63:0]  cand;
    logic signed [63:0]  best_val;
    int unsigned         m;
    int unsigned         best;
    int unsigned         n;
    bit                  have;
    m = (w.ran_mode >= 2) ? 0 : int'(w.ran_mode);
    // a counter that went backwards counts from zero
    elapsed = (w.tick_count >= tick_hist) ? w.tick_count - tick_hist : w.tick_count;
    tick_hist = w.tick_count;
    // divisor kept at 65 bits so an elapsed of all ones divides by 2^64
    span = {1'b0, elapsed} + 65'd1;
    scaled = (128'(w.conflict_count) * 128'd10000) << FRAC;
    quot = scaled / {63'd0, span};
    reward = (quot[127:64] != '0) ? '1 : quot[63:0];
    blend = $signed({{64{arm_score[m][63]}}, arm_score[m]}) * KEEP_Q16
          + ($signed({64'd0, reward}) * 128'sd3 - $signed({64'd0, arm_reward[m]}) * 128'sd2)
            * FRESH_Q16;
    blend = blend >>> 16;
    arm_score[m] = clip_s64(blend);
    arm_reward[m] = reward;
    n = (modes_sel > 2) ? 2 : int'(modes_sel);
    best = m;
    have = 1'b0;
    best_val = '0;
    for (int unsigned i = 0; i < n; i++) begin
      cand = arm_score[i];
      if (i == m) begin
        blend = $signed({{64{cand[63]}}, cand}) * $signed({112'd0, decay_now});
        cand = clip_s64(blend >>> 15);
      end
      // strict compare: ties stay with the lower index
      if (!have || cand > best_val) begin
        have = 1'b1;
        best_val = cand;
        best = i;
      end
    end
    if (best == m) begin
      decay_now = 16'((32'(decay_now) * DECAY_MULT) >> 15);
    end else begin
      decay_now = DECAY_UNIT;
    end
    pick_tally[best] = pick_tally[best] + 32'd1;
    pick.chosen_mode  = best[0];
    pick.reward_value = reward;
    pick.chosen_total = pick_tally[best];
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one input word, hold it until accepted, then queue its expected result.
  task automatic offer_word(input in_word_t w, input logic typed, input out_word_t want);
    int unsigned gap;
    out_word_t   forecast;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pick_next_mode(w, forecast);
    awaited_picks.push_back(typed ? want : forecast);
    last_choice = forecast.chosen_mode;
  endtask

  // Drop valid, let every result drain, then write modes_in_use while the block is idle.
  task automatic set_modes(input logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    while (awaited_picks.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    modes_sel = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Build a random word: mostly the well-formed loop (run the mode just chosen, with a
  // forward-moving counter), the rest switches, out-of-range modes and counter jumps.
  function automatic in_word_t random_word();
    in_word_t w;
    case ($urandom_range(0, 19))
      0: tick_now = tick_now - 64'($urandom_range(1, 5000));
      1: tick_now = {$urandom, $urandom};
      2: tick_now = $urandom_range(0, 1) ? '0 : '1;
      3: tick_now = tick_now + ({$urandom, $urandom} >> $urandom_range(0, 63));
      default: tick_now = tick_now + 64'($urandom_range(0, 3000));
    endcase
    w.tick_count = tick_now;
    case ($urandom_range(0, 9))
      0: w.conflict_count = '0;
      1: w.conflict_count = '1;
      2: w.conflict_count = $urandom;
      default: w.conflict_count = $urandom_range(0, 2000);
    endcase
    case ($urandom_range(0, 9))
      0, 1: w.ran_mode = MODE_W'($urandom_range(0, 1));
      2: w.ran_mode = MODE_W'($urandom_range(2, 3));
      default: w.ran_mode = {1'b0, last_choice};
    endcase
    return w;
  endfunction

  // Compare each accepted result word with the oldest pending expectation.
  task automatic check_pick(input out_word_t got);
    out_word_t want;
    if (awaited_picks.size() == 0) begin
      flag_mismatch("result word with nothing pending", got.reward_value, '0);
      return;
    end
    want = awaited_picks.pop_front();
    if (got.chosen_mode !== want.chosen_mode) begin
      flag_mismatch("chosen_mode", 64'(got.chosen_mode), 64'(want.chosen_mode));
    end
    if (got.reward_value !== want.reward_value) begin
      flag_mismatch("reward_value", got.reward_value, want.reward_value);
    end
    if (got.chosen_total !== want.chosen_total) begin
      flag_mismatch("chosen_total", 64'(got.chosen_total), 64'(want.chosen_total));
    end
  endtask

  // Result side: stall ready a random number of cycles per word, then take it.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_pick(out_data_o);
    end
  end

  // Stimulus: reset, directed table, then random phases across register settings.
  initial begin
    logic [CFG_W-1:0] phase_modes [PHASES];
    int unsigned      sent;
    phase_modes = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd2};

    // predictor reset state mirrors the block's reset
    modes_sel = MODES_RESET;
    tick_hist = '0;
    arm_reward = '{default: '0};
    arm_score = '{default: '0};
    decay_now = DECAY_UNIT;
    pick_tally = '{default: '0};

    // Directed rows. The first two are plain enough to type in: all-zero scores tie
    // and the lower mode wins; the largest elapsed divides by 2^64 and gives zero.
    opening_rows[0]  = '{'{64'd0, 32'd0, 2'd0}, 1'b1, '{1'b0, 64'd0, 32'd1}};
    opening_rows[1]  = '{'{'1, '1, 2'd1}, 1'b1, '{1'b0, 64'd0, 32'd2}};
    // mode two taken as zero, counter unchanged
    opening_rows[2]  = '{'{'1, 32'd1, 2'd2}, 1'b0, '0};
    // counter backwards, mode three
    opening_rows[3]  = '{'{64'd5, 32'd1000, 2'd3}, 1'b0, '0};
    // largest conflict count over short spans
    opening_rows[4]  = '{'{64'd100, '1, 2'd1}, 1'b0, '0};
    opening_rows[5]  = '{'{64'd101, '1, 2'd1}, 1'b0, '0};
    // reward collapse gives a negative trend
    opening_rows[6]  = '{'{64'd1000, 32'd0, 2'd1}, 1'b0, '0};
    opening_rows[7]  = '{'{64'd2000, 32'd50, 2'd0}, 1'b0, '0};
    opening_rows[8]  = '{'{64'd2000, 32'd50, 2'd0}, 1'b0, '0};
    opening_rows[9]  = '{'{64'h8000_0000_0000_0000, 32'd123456, 2'd1}, 1'b0, '0};
    opening_rows[10] = '{'{64'h7FFF_FFFF_FFFF_FFFF, 32'd7, 2'd0}, 1'b0, '0};
    // run of repeats on mode zero to shrink the decay
    opening_rows[11] = '{'{64'h8000_0000_0000_000A, 32'd2000, 2'd0}, 1'b0, '0};
    opening_rows[12] = '{'{64'h8000_0000_0000_0014, 32'd2000, 2'd0}, 1'b0, '0};
    opening_rows[13] = '{'{64'h8000_0000_0000_001E, 32'd2000, 2'd0}, 1'b0, '0};
    opening_rows[14] = '{'{64'h8000_0000_0000_0028, 32'd0, 2'd1}, 1'b0, '0};
    opening_rows[15] = '{'{64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 2'd3}, 1'b0, '0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < OPENING_ROWS; r++) begin
      offer_word(opening_rows[r].word, opening_rows[r].typed, opening_rows[r].want);
    end
    tick_now = opening_rows[OPENING_ROWS-1].word.tick_count;

    // phase zero keeps the reset setting; later phases rewrite the register
    sent = 0;
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        set_modes(phase_modes[p]);
      end
      for (int unsigned k = 0; k < RANDOM_PER_PHASE; k++) begin
        // toggle between idling and back-to-back stretches
        if (sent % 40 == 0) begin
          steady = ($urandom_range(0, 2) == 0);
        end
        offer_word(random_word(), 1'b0, '0);
        sent++;
      end
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (awaited_picks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS two_arm_bandit_mode_selector");
    end else begin
      $display("FAIL two_arm_bandit_mode_selector");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5ms;
    $display("FAIL two_arm_bandit_mode_selector");
    $finish;
  end

endmodule
